>>> sv/rsams_pkg.sv
package rsams_pkg;

    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_QRY  = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [31:0] EMPTY_MIN = 32'h3f3f3f3f;
    localparam logic [31:0] OUT_CAP   = 32'h7fffffff;
    localparam logic [10:0] CC_RESET  = 11'd1024;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  row_low;
        logic [4:0]  row_high;
        logic [10:0] col_low;
        logic [10:0] col_high;
        logic [29:0] value;
    } req_t;

    typedef struct packed {
        logic [31:0] total;
        logic [30:0] smallest;
        logic [30:0] largest;
    } rsp_t;

    // clipped request handed from front to back
    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  rl;
        logic [4:0]  rh;
        logic [10:0] cl;
        logic [10:0] ch;
        logic [29:0] value;
        logic        empty;
    } cmd_t;

endpackage

>>> sv/rsams_front.sv
module rsams_front
    import rsams_pkg::*;
#(
    parameter int MAX_ROWS = 20,
    parameter int MAX_COLS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  req_t        req,
    output logic        q_valid,
    input  logic        q_pop,
    output cmd_t        q_cmd
);

    logic [10:0] cc_reg;
    cmd_t        q_mem [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    cmd_t        cmd;
    logic [31:0] cc;
    logic        do_push, do_pop;

    // clip spans and classify
    always_comb
    begin
        cc = 32'(cc_reg);
        if (cc < 32'd1)
            cc = 32'd1;
        if (cc > 32'(MAX_COLS))
            cc = 32'(MAX_COLS);
        cmd.action = req.action;
        cmd.value  = req.value;
        cmd.rl     = (req.row_low == 5'd0) ? 5'd1 : req.row_low;
        cmd.rh     = (32'(req.row_high) > 32'(MAX_ROWS)) ? 5'(MAX_ROWS) : req.row_high;
        cmd.cl     = (req.col_low == 11'd0) ? 11'd1 : req.col_low;
        cmd.ch     = (32'(req.col_high) > cc) ? 11'(cc) : req.col_high;
        cmd.empty  = (cmd.rl > cmd.rh) || (cmd.cl > cmd.ch);
    end

    assign full    = cnt_reg == 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_cmd   = q_mem[rp_reg];
    assign do_push = push && !full && req.action != ACT_NONE;
    assign do_pop  = q_pop && q_valid;

    // hold config and advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg  <= CC_RESET;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (cfg_we)
                cc_reg <= cfg_data;
            if (do_push)
                wp_reg <= !wp_reg;
            if (do_pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    // store the request
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wp_reg] <= cmd;
    end

endmodule

>>> sv/rsams_back.sv
module rsams_back
    import rsams_pkg::*;
#(
    parameter int MAX_ROWS = 20,
    parameter int MAX_COLS = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_pop,
    input  cmd_t q_cmd,
    output logic empty,
    input  logic pop,
    output rsp_t rsp
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_MOD} state_t;

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic [4:0]  r_reg;
    logic [10:0] c_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [31:0] tot_reg, lo_reg, hi_reg;
    logic        res_valid_reg;
    rsp_t        rsp_reg;

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;
    logic        we;
    logic [ADDR_W-1:0] addr;
    logic [31:0] wdata, x, tot_next, lo_next, hi_next;

    assign addr = (state_reg == S_CLEAR) ? clr_reg :
        ADDR_W'(32'(r_reg - 5'd1) * MAX_COLS + 32'(c_reg - 11'd1));
    assign x  = rdata_reg;
    assign we = (state_reg == S_CLEAR) ||
        (state_reg == S_MOD && cmd_reg.action != ACT_QRY);
    assign wdata = (state_reg == S_CLEAR) ? 32'd0 :
        (cmd_reg.action == ACT_ADD) ? x + 32'(cmd_reg.value) : 32'(cmd_reg.value);
    assign tot_next = tot_reg + x;
    assign lo_next  = (x < lo_reg) ? x : lo_reg;
    assign hi_next  = (x > hi_reg) ? x : hi_reg;

    assign q_pop = state_reg == S_IDLE && !res_valid_reg;
    assign empty = !res_valid_reg;
    assign rsp   = rsp_reg;

    // cell storage
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    // sequence the walk over cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == DEPTH - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid && !res_valid_reg)
                    begin
                        cmd_reg <= q_cmd;
                        r_reg   <= q_cmd.rl;
                        c_reg   <= q_cmd.cl;
                        tot_reg <= 32'd0;
                        lo_reg  <= 32'hffffffff;
                        hi_reg  <= 32'd0;
                        if (q_cmd.empty)
                        begin
                            if (q_cmd.action == ACT_QRY)
                            begin
                                rsp_reg       <= '{32'd0, EMPTY_MIN[30:0], 31'd0};
                                res_valid_reg <= 1'b1;
                            end
                        end
                        else
                            state_reg <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_MOD;
                S_MOD:
                begin
                    tot_reg <= tot_next;
                    lo_reg  <= lo_next;
                    hi_reg  <= hi_next;
                    state_reg <= S_READ;
                    if (c_reg == cmd_reg.ch)
                    begin
                        c_reg <= cmd_reg.cl;
                        if (r_reg == cmd_reg.rh)
                        begin
                            state_reg <= S_IDLE;
                            if (cmd_reg.action == ACT_QRY)
                            begin
                                rsp_reg.total    <= tot_next;
                                rsp_reg.smallest <= (lo_next > OUT_CAP) ? 31'(OUT_CAP)
                                                                        : lo_next[30:0];
                                rsp_reg.largest  <= (hi_next > OUT_CAP) ? 31'(OUT_CAP)
                                                                        : hi_next[30:0];
                                res_valid_reg    <= 1'b1;
                            end
                        end
                        else
                            r_reg <= r_reg + 5'd1;
                    end
                    else
                        c_reg <= c_reg + 11'd1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/range_set_add_sum_min_max_tree_top.sv
// Each request walks its rectangle one cell at a time: for each cell a read
// state, then a modify state that writes it back for add and set, after idle takes it.
// A new request is taken only in idle with no result waiting; a query result is
// registered with the modify of its last cell. Empty rectangles are done in idle.
// rst_n is asynchronous; after reset a clearing pass over all MAX_ROWS * MAX_COLS
// cells zeroes the cell memory before the first request starts.
module range_set_add_sum_min_max_tree_top
    import rsams_pkg::*;
#(
    parameter int MAX_ROWS = 20,
    parameter int MAX_COLS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  req_t        req,
    output logic        empty,
    input  logic        pop,
    output rsp_t        rsp
);

    logic q_valid, q_pop;
    cmd_t q_cmd;

    // accept and clip requests
    rsams_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .push(push), .full(full), .req(req),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
    );

    // carry out requests on the cell memory
    rsams_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .empty(empty), .pop(pop), .rsp(rsp)
    );

endmodule

>>> sv/rsams_checker.sv
module rsams_props
    import rsams_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic empty,
    input logic pop,
    input rsp_t rsp
);

    // hold a waiting result until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(rsp))
        else $error("result changed while waiting");

    // min above max only for an empty rectangle
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rsp.smallest > rsp.largest |->
            rsp.total == 32'd0 && rsp.smallest == EMPTY_MIN[30:0] && rsp.largest == 31'd0)
        else $error("min above max");

    // all-zero cells sum to zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rsp.largest == 31'd0 |-> rsp.total == 32'd0)
        else $error("nonzero sum with zero max");

endmodule

bind range_set_add_sum_min_max_tree_top rsams_props u_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .rsp(rsp)
);
